// ===== rtl/bsr_pkg.sv =====
// ----------------------------------------------------------------------------
// bsr_pkg
// Shared types and constants for the record sorter: record layout, cell
// control word and sequencer states.
// ----------------------------------------------------------------------------
package bsr_pkg;

  localparam int DEPTH     = 64;
  localparam int KEY_WIDTH = 32;
  localparam int TAG_WIDTH = 6;
  localparam int CNT_WIDTH = $clog2(DEPTH + 1);

  typedef struct packed {
    logic [KEY_WIDTH-1:0] key;
    logic [TAG_WIDTH-1:0] tag;
  } rec_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_SORT,
    CELL_SHIFT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     phase_odd;
    logic     descending;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SORT,
    ST_EMIT
  } state_t;

endpackage

// ===== rtl/bsr_if.sv =====
// ----------------------------------------------------------------------------
// bsr_if
// Valid/ready channels of the record sorter: record input, sorted output
// and the mode register write channel.
// ----------------------------------------------------------------------------
interface bsr_in_if;
  logic                          valid;
  logic                          ready;
  logic [bsr_pkg::KEY_WIDTH-1:0] sort_key;
  logic [bsr_pkg::TAG_WIDTH-1:0] record_tag;
  logic                          last_in;

  modport source (output valid, sort_key, record_tag, last_in, input ready);
  modport sink   (input valid, sort_key, record_tag, last_in, output ready);
endinterface

interface bsr_out_if;
  logic                          valid;
  logic                          ready;
  logic [bsr_pkg::KEY_WIDTH-1:0] sorted_key;
  logic [bsr_pkg::TAG_WIDTH-1:0] sorted_tag;
  logic                          last_out;
  logic                          overflow;

  modport source (output valid, sorted_key, sorted_tag, last_out, overflow, input ready);
  modport sink   (input valid, sorted_key, sorted_tag, last_out, overflow, output ready);
endinterface

interface bsr_cfg_if;
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/bsr_cell.sv =====
// ----------------------------------------------------------------------------
// bsr_cell
// One slot of the sorting row: loads a record, takes part in odd/even
// transposition with its neighbors, and shifts toward the head on emit.
// ----------------------------------------------------------------------------
module bsr_cell (
  input  logic                clk,
  input  bsr_pkg::cell_ctrl_t ctrl,
  input  logic                load_en,
  input  logic                pair_ok,
  input  logic                idx_odd,
  input  bsr_pkg::rec_t       load_rec,
  input  bsr_pkg::rec_t       left_rec,
  input  logic                left_swap,
  input  bsr_pkg::rec_t       right_rec,
  output bsr_pkg::rec_t       rec,
  output logic                swap
);
  import bsr_pkg::*;

  rec_t rec_next;
  logic left_member;

  assign left_member = (idx_odd == ctrl.phase_odd);

  always_comb begin
    if (ctrl.descending) begin
      swap = pair_ok && (rec.key < right_rec.key);
    end else begin
      swap = pair_ok && (rec.key > right_rec.key);
    end
  end

  always_comb begin
    rec_next = rec;
    unique case (ctrl.op)
      CELL_HOLD: rec_next = rec;
      CELL_LOAD: begin
        if (load_en) rec_next = load_rec;
      end
      CELL_SORT: begin
        if (left_member && swap) begin
          rec_next = right_rec;
        end else if (!left_member && left_swap) begin
          rec_next = left_rec;
        end
      end
      CELL_SHIFT: rec_next = right_rec;
      default: rec_next = rec;
    endcase
  end

  always_ff @(posedge clk) begin
    rec <= rec_next;
  end

endmodule

// ===== rtl/bubble_sort_records_by_key.sv =====
// ----------------------------------------------------------------------------
// bubble_sort_records_by_key
// Stable key sorter over a row of DEPTH cells using odd/even transposition.
// ----------------------------------------------------------------------------
// Load: one record per cycle; extra records drop.
// Sort: N transposition phases across the cell row, one per cycle.
// Emit: one sorted record per cycle from the head cell while the output is ready.
// Input waits during sort/emit, so a new set starts only after the last result.
// Reset clears the sequencer, count, overflow flag and mode; cells are not.
// ----------------------------------------------------------------------------
module bubble_sort_records_by_key (
  input  logic         clk,
  input  logic         rst,
  bsr_in_if.sink       rec_in,
  bsr_out_if.source    rec_out,
  bsr_cfg_if.sink      cfg
);
  import bsr_pkg::*;

  state_t               state, state_next;
  logic [CNT_WIDTH-1:0] count, count_next;
  logic [CNT_WIDTH-1:0] phase, phase_next;
  logic                 ovf, ovf_next;
  logic                 descending;
  logic                 in_beat, out_beat;
  logic                 room;
  cell_ctrl_t           ctrl;
  rec_t                 load_rec;
  rec_t                 cell_rec  [DEPTH];
  logic                 cell_swap [DEPTH];

  assign in_beat  = rec_in.valid && rec_in.ready;
  assign out_beat = rec_out.valid && rec_out.ready;
  assign room     = (count < CNT_WIDTH'(DEPTH));
  assign load_rec = '{key: rec_in.sort_key, tag: rec_in.record_tag};
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      descending <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      descending <= cfg.data;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (in_beat && rec_in.last_in) state_next = ST_SORT;
      end
      ST_SORT: begin
        if (phase == count - CNT_WIDTH'(1)) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_beat && count == CNT_WIDTH'(1)) state_next = ST_LOAD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    count_next = count;
    phase_next = phase;
    ovf_next   = ovf;
    unique case (state)
      ST_LOAD: begin
        phase_next = '0;
        if (in_beat) begin
          if (room) count_next = count + CNT_WIDTH'(1);
          else      ovf_next   = 1'b1;
        end
      end
      ST_SORT: phase_next = phase + CNT_WIDTH'(1);
      ST_EMIT: begin
        if (out_beat) begin
          count_next = count - CNT_WIDTH'(1);
          if (count == CNT_WIDTH'(1)) ovf_next = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    rec_in.ready    = (state == ST_LOAD);
    rec_out.valid   = (state == ST_EMIT);
    ctrl.phase_odd  = phase[0];
    ctrl.descending = descending;
    unique case (state)
      ST_LOAD: ctrl.op = in_beat ? CELL_LOAD : CELL_HOLD;
      ST_SORT: ctrl.op = CELL_SORT;
      ST_EMIT: ctrl.op = out_beat ? CELL_SHIFT : CELL_HOLD;
      default: ctrl.op = CELL_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      count <= '0;
      phase <= '0;
      ovf   <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      phase <= phase_next;
      ovf   <= ovf_next;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    rec_t left_rec, right_rec;
    logic left_swap;

    if (i == 0) begin : g_head
      assign left_rec  = cell_rec[i];
      assign left_swap = 1'b0;
    end else begin : g_mid
      assign left_rec  = cell_rec[i-1];
      assign left_swap = cell_swap[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_rec = cell_rec[i];
    end else begin : g_body
      assign right_rec = cell_rec[i+1];
    end

    bsr_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .load_en   (room && count == CNT_WIDTH'(i)),
      .pair_ok   (CNT_WIDTH'(i + 1) < count),
      .idx_odd   (1'(i % 2)),
      .load_rec  (load_rec),
      .left_rec  (left_rec),
      .left_swap (left_swap),
      .right_rec (right_rec),
      .rec       (cell_rec[i]),
      .swap      (cell_swap[i])
    );
  end

  assign rec_out.sorted_key = cell_rec[0].key;
  assign rec_out.sorted_tag = cell_rec[0].tag;
  assign rec_out.last_out   = (count == CNT_WIDTH'(1));
  assign rec_out.overflow   = ovf;

endmodule

// ===== rtl/bsr_checker.sv =====
// ----------------------------------------------------------------------------
// bsr_checker
// Port-level checks on the record sorter, bound to the top level.
// ----------------------------------------------------------------------------
module bsr_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic last_in,
  input logic out_valid,
  input logic out_ready,
  input logic last_out
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output beat withdrawn while stalled");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input taken while results pending");

  a_close_stops_input: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last_in |=> !in_ready && !out_valid)
    else $error("set close did not start sorting");

  a_last_ends_set: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last_out |=> !out_valid && in_ready)
    else $error("results continue past final beat");

endmodule

bind bubble_sort_records_by_key bsr_checker u_bsr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (rec_in.valid),
  .in_ready  (rec_in.ready),
  .last_in   (rec_in.last_in),
  .out_valid (rec_out.valid),
  .out_ready (rec_out.ready),
  .last_out  (rec_out.last_out)
);
